@@ src/apes_pkg.sv @@
// Shared types, constants and fixed-point helpers for the active particle Euler step.
// Used by apes_axis, apes_cordic_cell and the top level; no dependencies.
`default_nettype none
package apes_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int QW = 49;                       // width of a Q16.16 product after the shift
  localparam logic signed [32:0] Q_ONE = 33'sd65536;
  localparam logic signed [32:0] Q_SQRT2 = 33'sd92682;
  localparam logic signed [34:0] Q_HALF_PI = 35'sd102944;
  localparam logic signed [19:0] Q_PI_MAX = 20'sd205887;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    REG_TIME_STEP = 2'd0,
    REG_MOBILITY  = 2'd1,
    REG_INV_PERS  = 2'd2,
    REG_NOISE_GN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [34:0] x;
    logic signed [34:0] y;
    logic signed [19:0] z;
    logic               rot;   // take the angle, else keep the old direction
    logic signed [18:0] dir;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } kin_res_t;

  // Q16.16 product, floor rounding.
  function automatic logic signed [QW-1:0] qmul(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return QW'(p >>> 16);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [QW+1:0] v);
    if (v > (QW+2)'(S32_MAX)) return S32_MAX;
    else if (v < (QW+2)'(S32_MIN)) return S32_MIN;
    else return v[31:0];
  endfunction

  function automatic logic signed [19:0] atan_q(input logic [4:0] idx);
    logic signed [19:0] r;
    unique case (idx)
      5'd0: r = 20'sd51472;
      5'd1: r = 20'sd30386;
      5'd2: r = 20'sd16055;
      5'd3: r = 20'sd8150;
      5'd4: r = 20'sd4091;
      5'd5: r = 20'sd2047;
      5'd6: r = 20'sd1024;
      5'd7: r = 20'sd512;
      5'd8: r = 20'sd256;
      5'd9: r = 20'sd128;
      5'd10: r = 20'sd64;
      5'd11: r = 20'sd32;
      5'd12: r = 20'sd16;
      5'd13: r = 20'sd8;
      5'd14: r = 20'sd4;
      5'd15: r = 20'sd2;
      5'd16: r = 20'sd1;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/apes_axis.sv @@
// Five-stage displacement and velocity pipeline for one axis.
// Depends on apes_pkg.
`default_nettype none
module apes_axis (
  input  wire                clk,
  input  wire                en,
  input  wire         [30:0] dt,
  input  wire         [30:0] mu,
  input  wire         [30:0] itau,
  input  wire signed  [31:0] amp_r_i,   // registered alongside stage A
  input  wire signed  [31:0] f,
  input  wire signed  [31:0] v,
  input  wire signed  [31:0] al,
  input  wire signed  [31:0] nz,
  output logic signed [31:0] disp,
  output logic signed [31:0] new_vel
);
  import apes_pkg::*;

  logic signed [31:0]   v_a_r, v_b_r, v_c_r, v_d_r;
  logic signed [QW-1:0] mf_a_r, itv_a_r, itv_b_r, mual_a_r, mual_b_r;
  logic signed [31:0]   n_a_r, s1_b_r, inner_c_r, disp_d_r, dv_d_r, disp_e_r, nv_e_r;
  logic signed [QW-1:0] an_b_r, dp_c_r;
  logic signed [32:0]   dt_s, mu_s;

  assign dt_s = signed'({2'b00, dt});
  assign mu_s = signed'({2'b00, mu});

  always_ff @(posedge clk) begin
    if (en) begin
      // products of the inputs
      v_a_r    <= v;
      mf_a_r   <= qmul(mu_s, 33'(f));
      itv_a_r  <= qmul(signed'({2'b00, itau}), 33'(v));
      mual_a_r <= qmul(mu_s, 33'(al));
      n_a_r    <= sat32((QW+2)'(qmul(Q_SQRT2, 33'(nz))));
      // drift velocity and noise term
      v_b_r    <= v_a_r;
      s1_b_r   <= sat32((QW+2)'(v_a_r) + (QW+2)'(mf_a_r));
      an_b_r   <= qmul(33'(amp_r_i), 33'(n_a_r));
      itv_b_r  <= itv_a_r;
      mual_b_r <= mual_a_r;
      // scale drift, sum the velocity increment
      v_c_r     <= v_b_r;
      dp_c_r    <= qmul(dt_s, 33'(s1_b_r));
      inner_c_r <= sat32(-(QW+2)'(itv_b_r) + (QW+2)'(an_b_r) + (QW+2)'(mual_b_r));
      // scale increment
      v_d_r    <= v_c_r;
      disp_d_r <= sat32((QW+2)'(dp_c_r));
      dv_d_r   <= sat32((QW+2)'(qmul(dt_s, 33'(inner_c_r))));
      // add to old velocity
      disp_e_r <= disp_d_r;
      nv_e_r   <= sat32((QW+2)'(v_d_r) + (QW+2)'(dv_d_r));
    end
  end

  assign disp    = disp_e_r;
  assign new_vel = nv_e_r;

endmodule
`default_nettype wire

@@ src/apes_cordic_cell.sv @@
// One vectoring step of the CORDIC chain: shift-add on x and y, accumulate angle.
// Depends on apes_pkg.
`default_nettype none
module apes_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire                     clk,
  input  wire                     en,
  input  apes_pkg::cordic_t       c_i,
  output apes_pkg::cordic_t       c_o
);
  import apes_pkg::*;

  cordic_t c_nxt, c_r;
  logic signed [34:0] dx, dy;
  logic signed [19:0] at;

  assign dx = c_i.y >>> STAGE;
  assign dy = c_i.x >>> STAGE;
  assign at = atan_q(5'(STAGE));

  always_comb begin
    c_nxt = c_i;
    if (c_i.y > 35'sd0) begin
      c_nxt.x = c_i.x + dx;
      c_nxt.y = c_i.y - dy;
      c_nxt.z = c_i.z + at;
    end else begin
      c_nxt.x = c_i.x - dx;
      c_nxt.y = c_i.y + dy;
      c_nxt.z = c_i.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_o = c_r;

endmodule
`default_nettype wire

@@ src/active_particle_euler_step.sv @@
// Top level of the active particle Euler step: stream ports, register file,
// arithmetic lanes and CORDIC chain. Depends on apes_pkg, apes_axis, apes_cordic_cell.
//
// Usage: one particle enters as a word on the in_ channel, one result word
// leaves on the out_ channel, in order. The pipeline takes a word every cycle
// while it is not stalled. From acceptance to out_tvalid a word passes the quadrant
// pre-rotation register, one register per CORDIC cell and the output register.
// The x and y lanes finish after five stages and wait in a delay line until
// the angle catches up; the CORDIC chain length sets the latency.
// Throughput: one word per cycle while out_tready is high.
// Stall: when the output register holds a word that is not taken, the whole
// pipeline holds and in_tready drops; it rises again in the cycle the word
// is taken, so no bubble is lost.
// Reset (rst_n low, synchronous) empties the pipeline and loads the registers
// with their defaults (dt 655, mu 1.0, 1/tau 1.0, noise gain 10.0).
// Registers: APB at byte offsets 0, 4, 8, 12; write only while idle.
`default_nettype none
module active_particle_euler_step #(
  parameter int CORDIC_STAGES = apes_pkg::CORDIC_STAGES_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  // force_x, force_y, vel_x, vel_y, old_direction[18:0], motility[30:0],
  // align_x, align_y, noise_x, noise_y (lowest first), zero padded
  input  wire  [311:0] in_tdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  // disp_x, disp_y, new_vel_x, new_vel_y, new_direction[18:0], zero padded
  output logic [151:0] out_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [3:0]   cfg_paddr,
  input  wire  [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import apes_pkg::*;

  localparam int DLY = CORDIC_STAGES - 4;

  // register file
  logic [30:0] dt_r, mu_r, ip_r, ng_r;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 31'd655;
      mu_r <= 31'd65536;
      ip_r <= 31'd65536;
      ng_r <= 31'd655360;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        REG_TIME_STEP: dt_r <= cfg_pwdata[30:0];
        REG_MOBILITY:  mu_r <= cfg_pwdata[30:0];
        REG_INV_PERS:  ip_r <= cfg_pwdata[30:0];
        REG_NOISE_GN:  ng_r <= cfg_pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TIME_STEP: cfg_prdata = {1'b0, dt_r};
      REG_MOBILITY:  cfg_prdata = {1'b0, mu_r};
      REG_INV_PERS:  cfg_prdata = {1'b0, ip_r};
      REG_NOISE_GN:  cfg_prdata = {1'b0, ng_r};
    endcase
  end

  // input word fields
  logic signed [31:0] fx, fy, vx, vy, ax, ay, nx, ny;
  logic signed [18:0] od;
  logic        [30:0] mot;

  assign fx  = in_tdata[31:0];
  assign fy  = in_tdata[63:32];
  assign vx  = in_tdata[95:64];
  assign vy  = in_tdata[127:96];
  assign od  = in_tdata[146:128];
  assign mot = in_tdata[177:147];
  assign ax  = in_tdata[209:178];
  assign ay  = in_tdata[241:210];
  assign nx  = in_tdata[273:242];
  assign ny  = in_tdata[305:274];

  // the whole pipeline advances together; hold it while a result waits
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // noise amplitude, shared by both lanes
  logic signed [31:0] amp_r;
  logic        [30:0] itau;
  assign itau = (ax == 32'sd0) ? Q_ONE[30:0] : ip_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      amp_r <= sat32((QW+2)'(qmul(signed'({2'b00, mot}), signed'({2'b00, ng_r}))));
    end
  end

  kin_res_t kin;

  apes_axis u_axis_x (
    .clk(clk), .en(adv), .dt(dt_r), .mu(mu_r), .itau(itau), .amp_r_i(amp_r),
    .f(fx), .v(vx), .al(ax), .nz(nx), .disp(kin.disp_x), .new_vel(kin.new_vel_x)
  );

  apes_axis u_axis_y (
    .clk(clk), .en(adv), .dt(dt_r), .mu(mu_r), .itau(itau), .amp_r_i(amp_r),
    .f(fy), .v(vy), .al(ay), .nz(ny), .disp(kin.disp_y), .new_vel(kin.new_vel_y)
  );

  // align lane results with the end of the CORDIC chain
  kin_res_t dly_r [DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= kin;
    end
  end

  for (genvar k = 1; k < DLY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  // quadrant pre-rotation: bring negative x into the right half plane
  cordic_t pre_nxt;
  cordic_t chain [CORDIC_STAGES+1];
  logic signed [34:0] x35, y35;

  assign x35 = 35'(vx);
  assign y35 = 35'(vy);

  always_comb begin
    pre_nxt.rot = (vx != 32'sd0) && (vy != 32'sd0);
    pre_nxt.dir = od;
    pre_nxt.x   = x35;
    pre_nxt.y   = y35;
    pre_nxt.z   = 20'sd0;
    if (vx < 32'sd0) begin
      if (vy > 32'sd0) begin
        pre_nxt.x = y35;
        pre_nxt.y = -x35;
        pre_nxt.z = Q_HALF_PI[19:0];
      end else begin
        pre_nxt.x = -y35;
        pre_nxt.y = x35;
        pre_nxt.z = -Q_HALF_PI[19:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0] <= pre_nxt;
    end
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
    apes_cordic_cell #(.STAGE(s)) u_cell (
      .clk(clk), .en(adv), .c_i(chain[s]), .c_o(chain[s+1])
    );
  end

  // valid flags travel beside the chain
  logic [CORDIC_STAGES:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[CORDIC_STAGES-1:0], in_tvalid};
    end
  end

  // clamp the angle and register the result word
  cordic_t            fin;
  logic signed [19:0] zc;
  logic signed [18:0] dir_nxt;
  logic [151:0]       out_data_r;

  assign fin = chain[CORDIC_STAGES];

  always_comb begin
    zc = fin.z;
    if (zc > Q_PI_MAX) zc = Q_PI_MAX;
    if (zc < -Q_PI_MAX) zc = -Q_PI_MAX;
    dir_nxt = fin.rot ? zc[18:0] : fin.dir;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {5'd0, dir_nxt, dly_r[DLY-1].new_vel_y, dly_r[DLY-1].new_vel_x,
                     dly_r[DLY-1].disp_y, dly_r[DLY-1].disp_x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking bench for active_particle_euler_step: drives particle words on the
// in_ stream, predicts or types in each result word and compares it field by field.
// Depends on apes_pkg and the RTL top level only.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import apes_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 2;
  localparam longint LIMIT = 2000000;
  localparam longint P_SQRT2 = 92682;
  localparam longint P_HALF_PI = 102944;
  localparam longint P_PI_MAX = 205887;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [311:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [151:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  active_particle_euler_step #(.CORDIC_STAGES(STAGES)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    logic [31:0] fx, fy, vx, vy;
    logic [18:0] dir;
    logic [30:0] mot;
    logic [31:0] ax, ay, nx, ny;
  } particle_t;

  typedef struct {
    logic [31:0] dx, dy, wx, wy;
    logic [18:0] dir;
  } step_t;

  // predictor's copy of the register file
  longint dt_q = 655, mu_q = 65536, itau_q = 65536, gain_q = 655360;

  step_t expected_steps[$];
  int errors = 0;
  longint cycles = 0;
  bit long_hold = 0;

  function automatic longint floor16(longint v);
    return v >>> 16;  // arithmetic shift is floor
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qprod(longint a, longint b);
    return floor16(a * b);
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, t, ddx, ddy;
    z = 0;
    if (x < 0) begin
      if (y > 0) begin
        t = x; x = y; y = -t; z = P_HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -P_HALF_PI;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      ddx = y >>> i;
      ddy = x >>> i;
      if (y > 0) begin
        x += ddx; y -= ddy; z += atan_entry(i);
      end else begin
        x -= ddx; y += ddy; z -= atan_entry(i);
      end
    end
    if (z > P_PI_MAX) z = P_PI_MAX;
    if (z < -P_PI_MAX) z = -P_PI_MAX;
    return z;
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                        64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tab[i] : 0;
  endfunction

  // one lane of the step: displacement and new velocity
  function automatic void lane(longint f, longint v, longint al, longint nz, longint amp,
                               longint itau, output longint d, output longint nv);
    longint n, inner;
    n = clamp32(qprod(P_SQRT2, nz));
    inner = clamp32(-qprod(itau, v) + qprod(amp, n) + qprod(mu_q, al));
    d = clamp32(qprod(dt_q, clamp32(v + qprod(mu_q, f))));
    nv = clamp32(v + clamp32(qprod(dt_q, inner)));
  endfunction

  function automatic step_t euler_step(particle_t p);
    step_t r;
    longint amp, itau, d0, d1, w0, w1, vx, vy;
    vx = longint'(signed'(p.vx));
    vy = longint'(signed'(p.vy));
    amp = clamp32(qprod(longint'(p.mot), gain_q));
    itau = (p.ax == 0) ? 65536 : itau_q;
    lane(signed'(p.fx), vx, signed'(p.ax), signed'(p.nx), amp, itau, d0, w0);
    lane(signed'(p.fy), vy, signed'(p.ay), signed'(p.ny), amp, itau, d1, w1);
    r.dx = d0[31:0]; r.dy = d1[31:0]; r.wx = w0[31:0]; r.wy = w1[31:0];
    if (vx != 0 && vy != 0) r.dir = 19'(angle_of(vy, vx));
    else r.dir = p.dir;
    return r;
  endfunction

  function automatic logic [311:0] pack_word(particle_t p);
    return {p.ny, p.nx, p.ay, p.ax, p.mot, p.dir, p.vy, p.vx, p.fy, p.fx};
  endfunction

  function automatic logic [31:0] any32();
    unique case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    p.fx = any32(); p.fy = any32(); p.vx = any32(); p.vy = any32();
    p.dir = 19'($urandom_range(0, 2 * 205887) - 205887);
    p.mot = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
    p.ax = ($urandom_range(0, 3) == 0) ? 32'h0 : any32();
    p.ay = any32(); p.nx = any32(); p.ny = any32();
    return p;
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // register write: setup then access, pready is always high
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= 4'(idx) << 2; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    unique case (idx)
      REG_TIME_STEP: dt_q = value[30:0];
      REG_MOBILITY:  mu_q = value[30:0];
      REG_INV_PERS:  itau_q = value[30:0];
      REG_NOISE_GN:  gain_q = value[30:0];
    endcase
  endtask

  task automatic drain();
    while (expected_steps.size() != 0) @(posedge clk);
    wait_cycles(LATENCY + 2);
  endtask

  // offer one word; hold tvalid high back-to-back when there is no gap
  task automatic send_particle(particle_t p, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      wait_cycles(gap);
    end
    in_tdata <= pack_word(p);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_steps.push_back(euler_step(p));
  endtask

  // directed rows: expected typed in only where obvious, else predicted
  typedef struct {
    particle_t p;
    bit typed;
    step_t want;
  } row_t;

  task automatic run_rows();
    row_t rows[$];
    row_t r;
    particle_t z;
    z = '{default: '0};
    // all zero: nothing moves, old direction kept
    r.p = z; r.p.dir = 19'sd205887; r.typed = 1;
    r.want = '{32'h0, 32'h0, 32'h0, 32'h0, 19'sd205887};
    rows.push_back(r);
    r.p = z; r.p.dir = -19'sd205887; r.want.dir = -19'sd205887; rows.push_back(r);
    r.typed = 0;
    // extremes of each field
    r.p = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 19'sd0,
            31'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
    rows.push_back(r);
    r.p = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 19'sd100,
            31'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    rows.push_back(r);
    // one velocity component zero keeps the direction
    r.p = z; r.p.vx = 32'h10000; r.p.dir = 19'sd1234; rows.push_back(r);
    r.p = z; r.p.vy = 32'hffff0000; r.p.dir = -19'sd777; rows.push_back(r);
    // four quadrants, and the most negative x through the pre-rotation
    r.p = z; r.p.vx = 32'h10000; r.p.vy = 32'h10000; rows.push_back(r);
    r.p = z; r.p.vx = 32'hffff0000; r.p.vy = 32'h10000; rows.push_back(r);
    r.p = z; r.p.vx = 32'hffff0000; r.p.vy = 32'hffff0000; rows.push_back(r);
    r.p = z; r.p.vx = 32'h10000; r.p.vy = 32'hffff0000; rows.push_back(r);
    r.p = z; r.p.vx = 32'h80000000; r.p.vy = 32'hffffffff; rows.push_back(r);
    // external particle against aligned one
    r.p = rand_particle(); r.p.ax = 32'h0; rows.push_back(r);
    r.p.ax = 32'h1; rows.push_back(r);
    // noise saturation path
    r.p = z; r.p.nx = 32'h7fffffff; r.p.ny = 32'h80000000; r.p.mot = 31'h7fffffff;
    rows.push_back(r);
    foreach (rows[i]) begin
      send_particle(rows[i].p, 0);
      if (rows[i].typed) begin
        expected_steps.pop_back();
        expected_steps.push_back(rows[i].want);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        wait_cycles(200);
        long_hold = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        wait_cycles(stall);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // check each taken result word against the oldest expectation
  always @(posedge clk) begin
    step_t want;
    logic [18:0] got_dir;
    if (rst_n && out_tvalid && out_tready) begin
      got_dir = out_tdata[146:128];
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_steps.pop_front();
        if (out_tdata[31:0] !== want.dx || out_tdata[63:32] !== want.dy ||
            out_tdata[95:64] !== want.wx || out_tdata[127:96] !== want.wy ||
            got_dir !== want.dir) begin
          $display("%0t: expected %h %h %h %h %h got %h %h %h %h %h", $time,
                   want.dx, want.dy, want.wx, want.wy, want.dir, out_tdata[31:0],
                   out_tdata[63:32], out_tdata[95:64], out_tdata[127:96], got_dir);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("active_particle_euler_step: mismatch");
      $finish;
    end
  end

  initial begin
    int gap;
    wait_cycles(3);
    rst_n <= 1'b1;
    @(posedge clk);
    run_rows();
    drain();
    // settings: extremes, typical, random and default values, every register written
    for (int phase = 0; phase < 5; phase++) begin
      unique case (phase)
        0: begin
          write_reg(REG_TIME_STEP, 32'h7fffffff); write_reg(REG_MOBILITY, 32'h0);
          write_reg(REG_INV_PERS, 32'h7fffffff); write_reg(REG_NOISE_GN, 32'h0);
        end
        1: begin
          write_reg(REG_TIME_STEP, 32'h0); write_reg(REG_MOBILITY, 32'h7fffffff);
          write_reg(REG_INV_PERS, 32'h0); write_reg(REG_NOISE_GN, 32'hffffffff);
        end
        2: begin
          write_reg(REG_TIME_STEP, 32'd6554); write_reg(REG_MOBILITY, 32'd32768);
          write_reg(REG_INV_PERS, 32'd131072); write_reg(REG_NOISE_GN, 32'd207243);
        end
        3: begin
          write_reg(REG_TIME_STEP, $urandom); write_reg(REG_MOBILITY, $urandom);
          write_reg(REG_INV_PERS, $urandom); write_reg(REG_NOISE_GN, $urandom);
        end
        default: begin
          write_reg(REG_TIME_STEP, 32'd655); write_reg(REG_MOBILITY, 32'd65536);
          write_reg(REG_INV_PERS, 32'd65536); write_reg(REG_NOISE_GN, 32'd655360);
        end
      endcase
      for (int n = 0; n < 290; n++) begin
        if (phase == 2 && n == 20) long_hold = 1;
        // sender pause until all results are in
        if (phase == 3 && n == 100) begin
          in_tvalid <= 1'b0;
          while (expected_steps.size() != 0) @(posedge clk);
        end
        gap = ($urandom_range(0, 2) == 0 || (phase == 2 && n < 120)) ? 0
              : $urandom_range(0, 16);
        send_particle(rand_particle(), gap);
      end
      in_tvalid <= 1'b0;
      drain();
    end
    if (errors == 0) begin
      $display("active_particle_euler_step: match");
    end else begin
      $display("active_particle_euler_step: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
